>>> src/frequency_caesar_breaker_core_assert.svh
// Assertion macros for the checker module of the breaker core.
// Each macro expects a clock named aclk and an active-low reset named aresetn
// in the scope where it is used.
`ifndef FREQUENCY_CAESAR_BREAKER_CORE_ASSERT_SVH
`define FREQUENCY_CAESAR_BREAKER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FCB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("fcb check failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define FCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("fcb check failed: next-cycle rule");

`endif

>>> src/fcb_pkg.sv
`timescale 1ns / 1ps

package fcb_pkg;

    // Sizes
    localparam int COUNT_WIDTH = 16;
    localparam int NUM_LETTERS = 26;
    localparam int LETTER_W    = 5;
    localparam int CHAR_W      = 8;
    localparam int OP_W        = 2;

    // Letter index that the most frequent letter maps onto ('e')
    localparam logic [LETTER_W-1:0] TARGET_IDX = 5'd4;

    // ASCII bounds
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_COUNT   = 2'd1;
    localparam logic [OP_W-1:0] OP_DECRYPT = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [LETTER_W-1:0]    letter_t;
    typedef logic [CHAR_W-1:0]      char_t;

    // Byte classification
    typedef struct packed {
        logic    is_letter;
        logic    upper;
        letter_t idx;
    } char_class_t;

    // Update command into the frequency table
    typedef struct packed {
        logic    en;
        logic    clear;
        logic    count;
        letter_t idx;
    } tally_cmd_t;

    // Argmax status out of the frequency table
    typedef struct packed {
        letter_t best_letter;
        logic    letters_seen;
    } freq_status_t;

    function automatic char_class_t classify(input char_t ch);
        char_class_t r;
        char_t       off_u;
        char_t       off_l;
        r     = '0;
        off_u = ch - CHAR_UPPER_A;
        off_l = ch - CHAR_LOWER_A;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            r.is_letter = 1'b1;
            r.upper     = 1'b1;
            r.idx       = off_u[LETTER_W-1:0];
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            r.is_letter = 1'b1;
            r.upper     = 1'b0;
            r.idx       = off_l[LETTER_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/fcb_freq_table.sv
`timescale 1ns / 1ps

// Letter counts with saturation and a running argmax (ties to the lower letter).
module fcb_freq_table (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fcb_pkg::tally_cmd_t  cmd,
    output fcb_pkg::freq_status_t status,
    output fcb_pkg::freq_status_t status_next
);

    fcb_pkg::count_t  counts_reg [fcb_pkg::NUM_LETTERS];
    fcb_pkg::count_t  best_count_reg;
    fcb_pkg::count_t  best_count_next;
    fcb_pkg::letter_t best_letter_reg;
    fcb_pkg::letter_t best_letter_next;

    fcb_pkg::count_t  cur_count;
    fcb_pkg::count_t  inc_count;
    logic             take_lead;

    // Saturating increment of the addressed count
    assign cur_count = counts_reg[cmd.idx];
    assign inc_count = (cur_count == '1) ? cur_count
                                         : cur_count + fcb_pkg::COUNT_WIDTH'(1);

    assign take_lead = (inc_count > best_count_reg) ||
                       (inc_count == best_count_reg && cmd.idx < best_letter_reg);

    // Next argmax
    always_comb begin
        best_count_next  = best_count_reg;
        best_letter_next = best_letter_reg;
        if (cmd.en) begin
            if (cmd.clear) begin
                best_count_next  = '0;
                best_letter_next = '0;
            end else if (cmd.count && take_lead) begin
                best_count_next  = inc_count;
                best_letter_next = cmd.idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.en && cmd.clear)) begin
            for (int i = 0; i < fcb_pkg::NUM_LETTERS; i++) begin
                counts_reg[i] <= '0;
            end
        end else if (cmd.en && cmd.count) begin
            counts_reg[cmd.idx] <= inc_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_count_reg  <= '0;
            best_letter_reg <= '0;
        end else begin
            best_count_reg  <= best_count_next;
            best_letter_reg <= best_letter_next;
        end
    end

    assign status.best_letter       = best_letter_reg;
    assign status.letters_seen      = (best_count_reg != '0);
    assign status_next.best_letter  = best_letter_next;
    assign status_next.letters_seen = (best_count_next != '0);

endmodule

>>> src/fcb_decrypt.sv
`timescale 1ns / 1ps

// Shift a letter so the most frequent letter lands on 'e'; case is kept.
module fcb_decrypt (
    input  fcb_pkg::char_t       char_in,
    input  fcb_pkg::char_class_t cls,
    input  fcb_pkg::freq_status_t status,
    input  logic                 decrypt_en,
    output fcb_pkg::char_t       char_out
);

    localparam logic [5:0] BIAS = 6'(fcb_pkg::NUM_LETTERS) + 6'(fcb_pkg::TARGET_IDX);
    localparam logic [5:0] MOD1 = 6'(fcb_pkg::NUM_LETTERS);
    localparam logic [5:0] MOD2 = 6'(2 * fcb_pkg::NUM_LETTERS);

    logic [5:0]       sum;
    logic [5:0]       wrapped;
    fcb_pkg::char_t   base;

    // idx + 26 + 4 - best stays in 5..55, so at most two subtractions
    assign sum = {1'b0, cls.idx} + BIAS - {1'b0, status.best_letter};

    always_comb begin
        if (sum >= MOD2) begin
            wrapped = sum - MOD2;
        end else if (sum >= MOD1) begin
            wrapped = sum - MOD1;
        end else begin
            wrapped = sum;
        end
    end

    assign base = cls.upper ? fcb_pkg::CHAR_UPPER_A : fcb_pkg::CHAR_LOWER_A;

    assign char_out = (decrypt_en && cls.is_letter && status.letters_seen)
                    ? base + {3'b000, wrapped[fcb_pkg::LETTER_W-1:0]}
                    : char_in;

endmodule

>>> src/frequency_caesar_breaker_core.sv
`timescale 1ns / 1ps

// Channel  | Ports                                            | Direction
// ---------+--------------------------------------------------+----------
// input    | s_valid s_ready s_operation s_char_in            | in
// result   | m_valid m_ready m_char_out m_top_letter          | out
//          | m_letters_seen                                   |
//
// One transfer per cycle sustained while m_ready stays high; each item passes through
// the input register, then the result register, before its result is given.
// Counts and argmax update in the cycle an item moves from input to result
// register, so back-to-back count and decrypt items see each other's effect.
// aresetn (synchronous, active low) zeroes all counts and the argmax.
// A stalled result holds; the input register still fills behind it.
module frequency_caesar_breaker_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fcb_pkg::OP_W-1:0]     s_operation,
    input  fcb_pkg::char_t               s_char_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output fcb_pkg::char_t               m_char_out,
    output fcb_pkg::letter_t             m_top_letter,
    output logic                         m_letters_seen
);

    logic                     in_valid_reg;
    logic [fcb_pkg::OP_W-1:0] in_op_reg;
    fcb_pkg::char_t           in_char_reg;

    logic                     out_valid_reg;
    fcb_pkg::char_t           out_char_reg;
    fcb_pkg::letter_t         out_best_reg;
    logic                     out_seen_reg;

    logic                     advance;
    fcb_pkg::char_class_t     cls;
    fcb_pkg::tally_cmd_t      cmd;
    fcb_pkg::freq_status_t    status;
    fcb_pkg::freq_status_t    status_next;
    fcb_pkg::char_t           out_char_next;

    // Handshake: item moves on when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_char_reg <= s_char_in;
        end
    end

    assign cls = fcb_pkg::classify(in_char_reg);

    // Table update command
    assign cmd.en    = advance;
    assign cmd.clear = (in_op_reg == fcb_pkg::OP_CLEAR);
    assign cmd.count = (in_op_reg == fcb_pkg::OP_COUNT) && cls.is_letter;
    assign cmd.idx   = cls.idx;

    fcb_freq_table u_freq_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .status_next (status_next)
    );

    fcb_decrypt u_decrypt (
        .char_in    (in_char_reg),
        .cls        (cls),
        .status     (status),
        .decrypt_en (in_op_reg == fcb_pkg::OP_DECRYPT),
        .char_out   (out_char_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_char_reg <= out_char_next;
            out_best_reg <= status_next.best_letter;
            out_seen_reg <= status_next.letters_seen;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_char_out     = out_char_reg;
    assign m_top_letter   = out_best_reg;
    assign m_letters_seen = out_seen_reg;

endmodule

>>> src/fcb_checker.sv
`timescale 1ns / 1ps

`include "frequency_caesar_breaker_core_assert.svh"

// Port-level checks on the breaker core.
module fcb_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [fcb_pkg::OP_W-1:0] s_operation,
    input fcb_pkg::char_t           s_char_in,
    input logic                     m_valid,
    input logic                     m_ready,
    input fcb_pkg::char_t           m_char_out,
    input fcb_pkg::letter_t         m_top_letter,
    input logic                     m_letters_seen
);

    // Reported letter is always a real letter index
    `FCB_ASSERT_SAME(a_best_in_range, m_valid,
                     m_top_letter < 5'(fcb_pkg::NUM_LETTERS))

    // With nothing counted the argmax reads as letter a
    `FCB_ASSERT_SAME(a_empty_best_zero, m_valid && !m_letters_seen,
                     m_top_letter == '0)

    // An empty result register never blocks the input side
    `FCB_ASSERT_SAME(a_ready_when_drained, !m_valid, s_ready)

    // A stalled result holds with its payload
    `FCB_ASSERT_NEXT(a_result_holds, m_valid && !m_ready,
                     m_valid && $stable(m_char_out) && $stable(m_top_letter)
                     && $stable(m_letters_seen))

endmodule

bind frequency_caesar_breaker_core fcb_checker u_fcb_checker (.*);
